[rtl/dhj_pkg.sv]
// Shared constants, types and helper functions of the DH Jacobian core.
package dhj_pkg;

  localparam int unsigned MAX_JOINTS   = 8;
  localparam int unsigned CNT_W        = $clog2(MAX_JOINTS + 1);
  localparam int unsigned JIDX_W       = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int unsigned TAYLOR_TERMS = 10;
  localparam int unsigned TERM_IDX_W   = $clog2(2 * TAYLOR_TERMS);

  localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic        [31:0] ONE_Q30     = 32'h4000_0000;

  typedef enum logic {
    CMD_APPLY,
    CMD_EMIT
  } cmd_kind_e;

  // One queued command from the front end to the transform engine.
  typedef struct packed {
    cmd_kind_e           kind;
    logic                last;
    logic                ovf;
    logic signed [32:0]  theta;
    logic signed [31:0]  d;
    logic signed [31:0]  a;
    logic signed [31:0]  alpha;
  } dhj_cmd_t;

  // Series divisors: the sine terms first, then the cosine terms.
  localparam logic [8:0] TermDivisor [2*TAYLOR_TERMS] = '{
    9'd6,   9'd20,  9'd42,  9'd72,  9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420,
    9'd2,   9'd12,  9'd30,  9'd56,  9'd90,  9'd132, 9'd182, 9'd240, 9'd306, 9'd380
  };

  localparam logic [5:0] TermShift [2*TAYLOR_TERMS] = '{
    6'd34, 6'd36, 6'd37, 6'd38, 6'd38, 6'd39, 6'd39, 6'd40, 6'd40, 6'd40,
    6'd32, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd39, 6'd39, 6'd40, 6'd40
  };

  // Reciprocals floor(2^shift / divisor); the quotient is then off by at most two.
  localparam logic [31:0] TermRecip [2*TAYLOR_TERMS] = '{
    32'((64'd1 << 34) / 64'd6),   32'((64'd1 << 36) / 64'd20),
    32'((64'd1 << 37) / 64'd42),  32'((64'd1 << 38) / 64'd72),
    32'((64'd1 << 38) / 64'd110), 32'((64'd1 << 39) / 64'd156),
    32'((64'd1 << 39) / 64'd210), 32'((64'd1 << 40) / 64'd272),
    32'((64'd1 << 40) / 64'd342), 32'((64'd1 << 40) / 64'd420),
    32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 35) / 64'd12),
    32'((64'd1 << 36) / 64'd30),  32'((64'd1 << 37) / 64'd56),
    32'((64'd1 << 38) / 64'd90),  32'((64'd1 << 39) / 64'd132),
    32'((64'd1 << 39) / 64'd182), 32'((64'd1 << 39) / 64'd240),
    32'((64'd1 << 40) / 64'd306), 32'((64'd1 << 40) / 64'd380)
  };

  // Q2.30 product rounding: add half, then floor.
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = (p + 66'sd536870912) >>> 30;
    return s[35:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/dhj_intf.sv]
// Joint input and Jacobian column output channel interfaces.
interface dhj_joint_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] joint_angle;
  logic signed [31:0] angle_offset;
  logic signed [31:0] link_offset_d;
  logic signed [31:0] link_length_a;
  logic signed [31:0] link_twist;
  logic               final_joint;

  modport source (output valid, joint_angle, angle_offset, link_offset_d, link_length_a,
                  link_twist, final_joint, input ready);
  modport sink   (input valid, joint_angle, angle_offset, link_offset_d, link_length_a,
                  link_twist, final_joint, output ready);
endinterface

interface dhj_column_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lin_x;
  logic signed [31:0] lin_y;
  logic signed [31:0] lin_z;
  logic signed [31:0] ang_x;
  logic signed [31:0] ang_y;
  logic signed [31:0] ang_z;
  logic signed [31:0] tip_x;
  logic signed [31:0] tip_y;
  logic signed [31:0] tip_z;
  logic        [2:0]  column_index;
  logic               column_last;
  logic               joints_dropped;

  modport source (output valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, tip_x, tip_y, tip_z,
                  column_index, column_last, joints_dropped, input ready);
  modport sink   (input valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, tip_x, tip_y, tip_z,
                  column_index, column_last, joints_dropped, output ready);
endinterface

[rtl/dhj_front.sv]
// Front end: accepts joint words, counts capacity and queues commands.
module dhj_front import dhj_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  dhj_joint_if.sink    joint_i,
  output logic         cmd_valid_o,
  output dhj_cmd_t     cmd_o,
  input  logic         cmd_ready_i
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  dhj_cmd_t         fifo_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       fill_q;
  logic             accept, full, push, pop;
  dhj_cmd_t         entry;

  assign accept        = joint_i.valid & joint_i.ready;
  assign full          = (count_q == CNT_W'(MAX_JOINTS));
  // A joint beyond capacity is only queued when it closes the chain.
  assign push          = accept & (~full | joint_i.final_joint);
  assign pop           = cmd_valid_o & cmd_ready_i;
  assign joint_i.ready = (fill_q != 2'd2);
  assign cmd_valid_o   = (fill_q != 2'd0);
  assign cmd_o         = fifo_q[rd_q];

  always_comb begin
    entry.kind  = full ? CMD_EMIT : CMD_APPLY;
    entry.last  = joint_i.final_joint;
    entry.ovf   = ovf_q | full;
    entry.theta = {joint_i.joint_angle[31], joint_i.joint_angle}
                + {joint_i.angle_offset[31], joint_i.angle_offset};
    entry.d     = joint_i.link_offset_d;
    entry.a     = joint_i.link_length_a;
    entry.alpha = joint_i.link_twist;
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (joint_i.final_joint) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        ovf_d = ovf_q | full;
        if (!full) begin
          count_d = count_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      fill_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= entry;
    end
  end

endmodule

[rtl/dhj_sincos.sv]
// Iterative sine and cosine by quadrant reduction and a serial Taylor series.
module dhj_sincos import dhj_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  typedef enum logic [3:0] {
    SC_IDLE, SC_RED, SC_SQ, SC_XX, SC_TM, SC_TV, SC_TR, SC_TQ, SC_TD, SC_TF
  } sc_state_e;

  sc_state_e              state_q;
  logic signed [33:0]     r_q;
  logic        [1:0]      quad_q;
  logic        [31:0]     xx_q, t_q, v_q, qo_q;
  logic        [63:0]     p_q;
  logic signed [33:0]     acc_q, sraw_q;
  logic        [3:0]      kk_q;
  logic                   cos_q;

  logic        [30:0]           x;
  logic        [TERM_IDX_W-1:0] idx;
  logic        [33:0]           rem;
  logic        [33:0]           dv;
  logic        [31:0]           qn;
  logic signed [33:0]           acc_nx;
  logic signed [31:0]           sc, cc;

  function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v < 34'sd0) begin
      r = '0;
    end else if (v > 34'sd1073741824) begin
      r = 32'sh4000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign x   = {r_q[28:0], 2'b00};
  assign idx = cos_q ? TERM_IDX_W'(kk_q) + TERM_IDX_W'(TAYLOR_TERMS) : TERM_IDX_W'(kk_q);
  assign dv  = 34'(TermDivisor[idx]);
  assign rem = {2'b00, v_q} - {1'b0, p_q[32:0]};

  always_comb begin
    if (rem >= (dv << 1)) begin
      qn = qo_q + 32'd2;
    end else if (rem >= dv) begin
      qn = qo_q + 32'd1;
    end else begin
      qn = qo_q;
    end
    // Odd terms of both series are subtracted.
    acc_nx = kk_q[0] ? acc_q + $signed({2'b00, qn}) : acc_q - $signed({2'b00, qn});
    sc     = clamp_unit(sraw_q);
    cc     = clamp_unit(acc_nx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      r_q     <= '0;
      quad_q  <= '0;
      xx_q    <= '0;
      t_q     <= '0;
      v_q     <= '0;
      qo_q    <= '0;
      p_q     <= '0;
      acc_q   <= '0;
      sraw_q  <= '0;
      kk_q    <= '0;
      cos_q   <= 1'b0;
      done_o  <= 1'b0;
      sin_o   <= '0;
      cos_o   <= '0;
    end else begin
      unique case (state_q)
        SC_IDLE: begin
          if (start_i) begin
            r_q     <= {angle_i[32], angle_i};
            quad_q  <= '0;
            done_o  <= 1'b0;
            state_q <= SC_RED;
          end
        end
        SC_RED: begin
          if (r_q < 34'sd0) begin
            r_q    <= r_q + HALF_PI_Q28;
            quad_q <= quad_q - 2'd1;
          end else if (r_q >= HALF_PI_Q28) begin
            r_q    <= r_q - HALF_PI_Q28;
            quad_q <= quad_q + 2'd1;
          end else begin
            state_q <= SC_SQ;
          end
        end
        SC_SQ: begin
          p_q     <= 64'(x) * 64'(x);
          state_q <= SC_XX;
        end
        SC_XX: begin
          xx_q    <= 32'((p_q + 64'd536870912) >> 30);
          t_q     <= 32'(x);
          acc_q   <= $signed(34'(x));
          kk_q    <= '0;
          cos_q   <= 1'b0;
          state_q <= SC_TM;
        end
        SC_TM: begin
          p_q     <= 64'(t_q) * 64'(xx_q);
          state_q <= SC_TV;
        end
        SC_TV: begin
          v_q     <= 32'((p_q + 64'd536870912) >> 30);
          state_q <= SC_TR;
        end
        SC_TR: begin
          p_q     <= 64'(v_q) * 64'(TermRecip[idx]);
          state_q <= SC_TQ;
        end
        SC_TQ: begin
          qo_q    <= 32'(p_q >> TermShift[idx]);
          state_q <= SC_TD;
        end
        SC_TD: begin
          p_q     <= 64'(qo_q) * 64'(TermDivisor[idx]);
          state_q <= SC_TF;
        end
        SC_TF: begin
          if (kk_q == 4'(TAYLOR_TERMS - 1)) begin
            kk_q <= '0;
            if (!cos_q) begin
              sraw_q  <= acc_nx;
              cos_q   <= 1'b1;
              t_q     <= ONE_Q30;
              acc_q   <= $signed(34'(ONE_Q30));
              state_q <= SC_TM;
            end else begin
              state_q <= SC_IDLE;
              done_o  <= 1'b1;
              case (quad_q)
                2'd0: begin sin_o <= sc;  cos_o <= cc;  end
                2'd1: begin sin_o <= cc;  cos_o <= -sc; end
                2'd2: begin sin_o <= -sc; cos_o <= -cc; end
                default: begin sin_o <= -cc; cos_o <= sc; end
              endcase
            end
          end else begin
            t_q     <= qn;
            acc_q   <= acc_nx;
            kk_q    <= kk_q + 4'd1;
            state_q <= SC_TM;
          end
        end
        default: state_q <= SC_IDLE;
      endcase
    end
  end

endmodule

[rtl/dhj_back.sv]
// Back end: chains the joint transforms, stores frames and emits Jacobian columns.
module dhj_back import dhj_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cmd_valid_i,
  input  dhj_cmd_t     cmd_i,
  output logic         cmd_ready_o,
  dhj_column_if.source column_o
);

  typedef enum logic [3:0] {
    BK_IDLE, BK_WAIT, BK_PRE_MUL, BK_PRE_ACC, BK_TRN_MUL, BK_TRN_ACC, BK_ROT_MUL,
    BK_ROT_ACC, BK_COPY, BK_EM_RD, BK_EM_DIF, BK_EM_MUL, BK_EM_ACC, BK_EM_OUT
  } bk_state_e;

  localparam logic signed [31:0] One = 32'sh4000_0000;

  bk_state_e           state_q;
  logic signed [31:0]  rot_q  [9];
  logic signed [31:0]  nrot_q [9];
  logic signed [31:0]  mm_q   [9];
  logic signed [32:0]  tt_q   [3];
  logic signed [31:0]  trn_q  [3];
  logic signed [31:0]  lin_q  [3];
  logic signed [32:0]  dif_q  [3];
  logic signed [31:0]  a_q;
  logic signed [65:0]  p_q;
  logic signed [37:0]  acc_q;
  logic [2:0]          pre_q;
  logic [1:0]          i_q, j_q, k_q;
  logic [CNT_W-1:0]    loaded_q, col_q;
  logic                last_q, ovf_q;

  logic                colv_q, col_last_q, col_drop_q;
  logic [2:0]          col_idx_q;
  logic signed [31:0]  o_lin_q [3];
  logic signed [31:0]  o_ang_q [3];
  logic signed [31:0]  o_tip_q [3];

  logic [95:0]         axis_mem   [MAX_JOINTS];
  logic [95:0]         origin_mem [MAX_JOINTS];
  logic [95:0]         rd_axis_q, rd_org_q;

  logic                pop, sc_start, sc_done_t, sc_done_a;
  logic signed [31:0]  st, ct, sa, ca;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [35:0]  rnd;
  logic signed [37:0]  sum;
  logic signed [31:0]  z [3];
  logic signed [31:0]  o [3];
  logic [CNT_W+2:0]    col_ext;
  logic                out_free;
  logic                col_load;

  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    return 4'(r) * 4'd3 + 4'(c);
  endfunction

  assign cmd_ready_o = (state_q == BK_IDLE);
  assign pop         = cmd_valid_i & cmd_ready_o;
  assign sc_start    = pop & (cmd_i.kind == CMD_APPLY);
  assign rnd         = rnd30(p_q);
  assign out_free    = ~colv_q | column_o.ready;
  assign col_load    = (state_q == BK_EM_OUT) & out_free;
  assign col_ext     = (CNT_W + 3)'(col_q);

  assign z[0] = rd_axis_q[95:64];
  assign z[1] = rd_axis_q[63:32];
  assign z[2] = rd_axis_q[31:0];
  assign o[0] = rd_org_q[95:64];
  assign o[1] = rd_org_q[63:32];
  assign o[2] = rd_org_q[31:0];

  dhj_sincos u_sc_theta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sc_start),
    .angle_i (cmd_i.theta),
    .done_o  (sc_done_t),
    .sin_o   (st),
    .cos_o   (ct)
  );

  dhj_sincos u_sc_alpha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sc_start),
    .angle_i ({cmd_i.alpha[31], cmd_i.alpha}),
    .done_o  (sc_done_a),
    .sin_o   (sa),
    .cos_o   (ca)
  );

  // Operand selection for the single shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      BK_PRE_MUL: begin
        case (pre_q)
          3'd0:    begin mul_a = 33'(st);  mul_b = 33'(ca); end
          3'd1:    begin mul_a = 33'(st);  mul_b = 33'(sa); end
          3'd2:    begin mul_a = 33'(ct);  mul_b = 33'(ca); end
          3'd3:    begin mul_a = 33'(ct);  mul_b = 33'(sa); end
          3'd4:    begin mul_a = 33'(a_q); mul_b = 33'(ct); end
          default: begin mul_a = 33'(a_q); mul_b = 33'(st); end
        endcase
      end
      BK_TRN_MUL: begin
        mul_a = 33'(rot_q[idx3(i_q, j_q)]);
        mul_b = tt_q[j_q];
      end
      BK_ROT_MUL: begin
        mul_a = 33'(rot_q[idx3(i_q, k_q)]);
        mul_b = 33'(mm_q[idx3(k_q, j_q)]);
      end
      BK_EM_MUL: begin
        case (pre_q)
          3'd0:    begin mul_a = 33'(z[1]); mul_b = dif_q[2]; end
          3'd1:    begin mul_a = 33'(z[2]); mul_b = dif_q[1]; end
          3'd2:    begin mul_a = 33'(z[2]); mul_b = dif_q[0]; end
          3'd3:    begin mul_a = 33'(z[0]); mul_b = dif_q[2]; end
          3'd4:    begin mul_a = 33'(z[0]); mul_b = dif_q[1]; end
          default: begin mul_a = 33'(z[1]); mul_b = dif_q[0]; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    sum = 38'(rnd);
    case (state_q)
      BK_TRN_ACC: sum = ((j_q == 2'd0) ? 38'(trn_q[i_q]) : acc_q) + 38'(rnd);
      BK_ROT_ACC: sum = ((k_q == 2'd0) ? 38'sd0 : acc_q) + 38'(rnd);
      BK_EM_ACC:  sum = acc_q - 38'(rnd);
      default:    sum = 38'(rnd);
    endcase
  end

  // Frame store: written when a joint is taken, read one column at a time.
  always_ff @(posedge clk_i) begin
    if (sc_start) begin
      axis_mem[loaded_q[JIDX_W-1:0]]   <= {rot_q[2], rot_q[5], rot_q[8]};
      origin_mem[loaded_q[JIDX_W-1:0]] <= {trn_q[0], trn_q[1], trn_q[2]};
    end
    rd_axis_q <= axis_mem[col_q[JIDX_W-1:0]];
    rd_org_q  <= origin_mem[col_q[JIDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      rot_q      <= '{One, '0, '0, '0, One, '0, '0, '0, One};
      nrot_q     <= '{default: '0};
      mm_q       <= '{default: '0};
      tt_q       <= '{default: '0};
      trn_q      <= '{default: '0};
      lin_q      <= '{default: '0};
      dif_q      <= '{default: '0};
      a_q        <= '0;
      p_q        <= '0;
      acc_q      <= '0;
      pre_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      loaded_q   <= '0;
      col_q      <= '0;
      last_q     <= 1'b0;
      ovf_q      <= 1'b0;
      colv_q     <= 1'b0;
      col_last_q <= 1'b0;
      col_drop_q <= 1'b0;
      col_idx_q  <= '0;
      o_lin_q    <= '{default: '0};
      o_ang_q    <= '{default: '0};
      o_tip_q    <= '{default: '0};
    end else begin
      if (col_load) begin
        colv_q <= 1'b1;
      end else if (column_o.ready) begin
        colv_q <= 1'b0;
      end
      unique case (state_q)
        BK_IDLE: begin
          if (pop) begin
            last_q <= cmd_i.last;
            ovf_q  <= cmd_i.ovf;
            a_q    <= cmd_i.a;
            tt_q[2] <= {cmd_i.d[31], cmd_i.d};
            col_q  <= '0;
            state_q <= (cmd_i.kind == CMD_APPLY) ? BK_WAIT : BK_EM_RD;
          end
        end
        BK_WAIT: begin
          if (sc_done_t && sc_done_a) begin
            mm_q[0] <= ct;
            mm_q[3] <= st;
            mm_q[6] <= '0;
            mm_q[7] <= sa;
            mm_q[8] <= ca;
            pre_q   <= '0;
            state_q <= BK_PRE_MUL;
          end
        end
        BK_PRE_MUL: begin
          p_q     <= mul_a * mul_b;
          state_q <= BK_PRE_ACC;
        end
        BK_PRE_ACC: begin
          case (pre_q)
            3'd0:    mm_q[1] <= 32'(-rnd);
            3'd1:    mm_q[2] <= rnd[31:0];
            3'd2:    mm_q[4] <= rnd[31:0];
            3'd3:    mm_q[5] <= 32'(-rnd);
            3'd4:    tt_q[0] <= rnd[32:0];
            default: tt_q[1] <= rnd[32:0];
          endcase
          if (pre_q == 3'd5) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= BK_TRN_MUL;
          end else begin
            pre_q   <= pre_q + 3'd1;
            state_q <= BK_PRE_MUL;
          end
        end
        BK_TRN_MUL: begin
          p_q     <= mul_a * mul_b;
          state_q <= BK_TRN_ACC;
        end
        BK_TRN_ACC: begin
          acc_q <= sum;
          if (j_q == 2'd2) begin
            trn_q[i_q] <= sat32(sum);
            j_q        <= '0;
            if (i_q == 2'd2) begin
              i_q     <= '0;
              k_q     <= '0;
              state_q <= BK_ROT_MUL;
            end else begin
              i_q     <= i_q + 2'd1;
              state_q <= BK_TRN_MUL;
            end
          end else begin
            j_q     <= j_q + 2'd1;
            state_q <= BK_TRN_MUL;
          end
        end
        BK_ROT_MUL: begin
          p_q     <= mul_a * mul_b;
          state_q <= BK_ROT_ACC;
        end
        BK_ROT_ACC: begin
          acc_q <= sum;
          if (k_q == 2'd2) begin
            nrot_q[idx3(i_q, j_q)] <= sat32(sum);
            k_q <= '0;
            if (j_q == 2'd2) begin
              j_q <= '0;
              if (i_q == 2'd2) begin
                state_q <= BK_COPY;
              end else begin
                i_q     <= i_q + 2'd1;
                state_q <= BK_ROT_MUL;
              end
            end else begin
              j_q     <= j_q + 2'd1;
              state_q <= BK_ROT_MUL;
            end
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= BK_ROT_MUL;
          end
        end
        BK_COPY: begin
          rot_q    <= nrot_q;
          loaded_q <= loaded_q + CNT_W'(1);
          state_q  <= last_q ? BK_EM_RD : BK_IDLE;
        end
        BK_EM_RD: begin
          // The frame store read is registered, so it answers in the cycle after the column address settles.
          state_q <= BK_EM_DIF;
        end
        BK_EM_DIF: begin
          for (int n = 0; n < 3; n++) begin
            dif_q[n] <= {trn_q[n][31], trn_q[n]} - {o[n][31], o[n]};
          end
          pre_q   <= '0;
          state_q <= BK_EM_MUL;
        end
        BK_EM_MUL: begin
          p_q     <= mul_a * mul_b;
          state_q <= BK_EM_ACC;
        end
        BK_EM_ACC: begin
          if (!pre_q[0]) begin
            acc_q <= 38'(rnd);
          end else begin
            lin_q[pre_q[2:1]] <= sat32(sum);
          end
          if (pre_q == 3'd5) begin
            state_q <= BK_EM_OUT;
          end else begin
            pre_q   <= pre_q + 3'd1;
            state_q <= BK_EM_MUL;
          end
        end
        BK_EM_OUT: begin
          if (out_free) begin
            o_lin_q    <= lin_q;
            o_ang_q    <= z;
            o_tip_q    <= trn_q;
            col_idx_q  <= col_ext[2:0];
            col_last_q <= (col_q + CNT_W'(1) == loaded_q);
            col_drop_q <= ovf_q;
            if (col_q + CNT_W'(1) == loaded_q) begin
              rot_q    <= '{One, '0, '0, '0, One, '0, '0, '0, One};
              trn_q    <= '{default: '0};
              loaded_q <= '0;
              col_q    <= '0;
              state_q  <= BK_IDLE;
            end else begin
              col_q   <= col_q + CNT_W'(1);
              state_q <= BK_EM_RD;
            end
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

  assign column_o.valid          = colv_q;
  assign column_o.lin_x          = o_lin_q[0];
  assign column_o.lin_y          = o_lin_q[1];
  assign column_o.lin_z          = o_lin_q[2];
  assign column_o.ang_x          = o_ang_q[0];
  assign column_o.ang_y          = o_ang_q[1];
  assign column_o.ang_z          = o_ang_q[2];
  assign column_o.tip_x          = o_tip_q[0];
  assign column_o.tip_y          = o_tip_q[1];
  assign column_o.tip_z          = o_tip_q[2];
  assign column_o.column_index   = col_idx_q;
  assign column_o.column_last    = col_last_q;
  assign column_o.joints_dropped = col_drop_q;

endmodule

[rtl/dh_geometric_jacobian_core.sv]
// Geometric Jacobian core for a serial chain given by DH rows, one joint word at a time.
// Each joint runs the two Taylor units (20 terms each, after quadrant reduction) and then
// 42 products on the shared multiplier. The Jacobian columns are produced one at a time;
// the first follows the final joint's update, or the command of a dropped final joint.
// A two-word command queue lets joint words be taken while the engine is busy.
// Reset is asynchronous and active low; the running transform returns to identity.
module dh_geometric_jacobian_core import dhj_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  dhj_joint_if.sink    joint_i,
  dhj_column_if.source column_o
);

  logic     cmd_valid;
  logic     cmd_ready;
  dhj_cmd_t cmd;

  dhj_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .joint_i     (joint_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  dhj_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .column_o    (column_o)
  );

`ifndef SYNTHESIS
  // A command without a transform only arises from a dropped joint that ends the chain.
  a_emit_only_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready && cmd.kind == CMD_EMIT) |-> (cmd.ovf && cmd.last))
    else $error("emit-only command without overflow or final flag");

  a_col_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (column_o.valid && $past(column_o.valid && column_o.ready && !column_o.column_last))
    |-> (column_o.column_index == 3'($past(column_o.column_index) + 3'd1)))
    else $error("column index did not advance within a run");

  a_col_drop_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (column_o.valid && $past(column_o.valid && column_o.ready && !column_o.column_last))
    |-> (column_o.joints_dropped == $past(column_o.joints_dropped)))
    else $error("dropped flag changed within a run");
`endif

endmodule

[verif/tb_dh_geometric_jacobian_core.sv]
// Testbench for the DH geometric Jacobian core: directed and random chains against a predictor.
`timescale 1ns / 1ps

module tb_dh_geometric_jacobian_core;
  import dhj_pkg::*;

  typedef struct {
    logic signed [31:0] lin [3];
    logic signed [31:0] ang [3];
    logic signed [31:0] tip [3];
    logic [2:0]         idx;
    logic               last;
    logic               dropped;
  } column_t;

  localparam longint unsigned QUARTER_TURN = 64'd421657428;
  localparam longint          UNIT_Q30     = 64'sd1073741824;
  localparam int unsigned     STALL_LIMIT  = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dhj_joint_if  joint_if ();
  dhj_column_if column_if ();

  dh_geometric_jacobian_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .joint_i (joint_if.sink),
    .column_o(column_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: running transform and per-frame axis and origin.
  longint    rot [9];
  longint    trans [3];
  longint    axis_mem [3*MAX_JOINTS];
  longint    origin_mem [3*MAX_JOINTS];
  int        loaded;
  bit        overflowed;
  column_t   expected_columns [$];
  int        mismatches;
  bit        idle_enable;
  int        quiet_cycles;
  bit        timed_out;

  function automatic longint floor_sh30(longint v);
    return v >>> 30;
  endfunction

  function automatic longint rnd_q30(longint v);
    return floor_sh30(v + (64'sd1 <<< 29));
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic sine_cosine(input longint theta, output longint sn, output longint cs);
    longint q, r, s, c;
    longint unsigned x, xx, t;
    q = theta / longint'(QUARTER_TURN);
    r = theta - q * longint'(QUARTER_TURN);
    if (r < 0) begin
      r += longint'(QUARTER_TURN);
      q -= 1;
    end
    x = longint'(r) << 2;
    xx = (x * x + (64'd1 << 29)) >> 30;
    s = x;
    t = x;
    for (int k = 1; k <= 10; k++) begin
      t = ((t * xx + (64'd1 << 29)) >> 30) / longint'((2*k) * (2*k + 1));
      s += (k & 1) ? -longint'(t) : longint'(t);
    end
    c = UNIT_Q30;
    t = UNIT_Q30;
    for (int k = 1; k <= 10; k++) begin
      t = ((t * xx + (64'd1 << 29)) >> 30) / longint'((2*k - 1) * (2*k));
      c += (k & 1) ? -longint'(t) : longint'(t);
    end
    if (s < 0) s = 0;
    if (s > UNIT_Q30) s = UNIT_Q30;
    if (c < 0) c = 0;
    if (c > UNIT_Q30) c = UNIT_Q30;
    case (q & 3)
      0: begin sn = s; cs = c; end
      1: begin sn = c; cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endtask

  task automatic clear_chain();
    foreach (rot[i]) rot[i] = 0;
    rot[0] = UNIT_Q30;
    rot[4] = UNIT_Q30;
    rot[8] = UNIT_Q30;
    foreach (trans[i]) trans[i] = 0;
    loaded = 0;
    overflowed = 0;
  endtask

  // Chains one joint onto the running transform and queues columns on the final joint.
  task automatic predict_joint(input logic signed [31:0] ang, off, d, a, alpha,
                               input logic fin);
    longint st, ct, sa, ca, acc;
    longint m [9];
    longint t [3];
    longint nr [9];
    longint dx, dy, dz;
    column_t col;
    if (loaded < MAX_JOINTS) begin
      for (int j = 0; j < 3; j++) begin
        axis_mem[3*loaded + j] = rot[3*j + 2];
        origin_mem[3*loaded + j] = trans[j];
      end
      sine_cosine(longint'(ang) + longint'(off), st, ct);
      sine_cosine(longint'(alpha), sa, ca);
      m[0] = ct; m[1] = -rnd_q30(st * ca); m[2] = rnd_q30(st * sa);
      m[3] = st; m[4] = rnd_q30(ct * ca);  m[5] = -rnd_q30(ct * sa);
      m[6] = 0;  m[7] = sa;                m[8] = ca;
      t[0] = rnd_q30(longint'(a) * ct);
      t[1] = rnd_q30(longint'(a) * st);
      t[2] = d;
      for (int i = 0; i < 3; i++) begin
        acc = trans[i];
        for (int j = 0; j < 3; j++) acc += rnd_q30(rot[3*i + j] * t[j]);
        trans[i] = clamp32(acc);
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += rnd_q30(rot[3*i + k] * m[3*k + j]);
          nr[3*i + j] = clamp32(acc);
        end
      rot = nr;
      loaded++;
    end else begin
      overflowed = 1;
    end
    if (!fin) return;
    for (int i = 0; i < loaded; i++) begin
      dx = trans[0] - origin_mem[3*i];
      dy = trans[1] - origin_mem[3*i + 1];
      dz = trans[2] - origin_mem[3*i + 2];
      col.lin[0] = clamp32(rnd_q30(axis_mem[3*i+1] * dz) - rnd_q30(axis_mem[3*i+2] * dy));
      col.lin[1] = clamp32(rnd_q30(axis_mem[3*i+2] * dx) - rnd_q30(axis_mem[3*i] * dz));
      col.lin[2] = clamp32(rnd_q30(axis_mem[3*i] * dy) - rnd_q30(axis_mem[3*i+1] * dx));
      for (int j = 0; j < 3; j++) begin
        col.ang[j] = axis_mem[3*i + j];
        col.tip[j] = trans[j];
      end
      col.idx = i[2:0];
      col.last = (i + 1 == loaded);
      col.dropped = overflowed;
      expected_columns = {expected_columns, col};
    end
    clear_chain();
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Valid stays high from one word to the next unless an idle cycle is drawn.
  task automatic send_joint(input logic signed [31:0] ang, off, d, a, alpha,
                            input logic fin);
    while (idle_enable && $urandom_range(99) < 33) begin
      joint_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    joint_if.valid         <= 1'b1;
    joint_if.joint_angle   <= ang;
    joint_if.angle_offset  <= off;
    joint_if.link_offset_d <= d;
    joint_if.link_length_a <= a;
    joint_if.link_twist    <= alpha;
    joint_if.final_joint   <= fin;
    do @(posedge clk_i); while (!joint_if.ready);
    predict_joint(ang, off, d, a, alpha, fin);
  endtask

  function automatic logic signed [31:0] random_angle();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h3000_0000) - 32'h1800_0000;
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $urandom_range(32'h0680_0000) - 32'h0340_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] random_length();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  task automatic send_random_chain(input int joints);
    for (int j = 0; j < joints; j++)
      send_joint(random_angle(), random_angle(), random_length(), random_length(),
                 random_angle(), j == joints - 1);
  endtask

  // Extremes of every field, single joints and a full chain.
  task automatic test_directed();
    send_joint(0, 0, 0, 0, 0, 1'b1);
    send_joint(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
               32'sh7fff_ffff, 1'b1);
    send_joint(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh8000_0000, 1'b1);
    send_joint(32'sd421657428, 0, 32'sh0001_0000, 32'sh0002_0000, -32'sd421657428, 1'b0);
    send_joint(-32'sd1, 32'sd843314856, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd1, 1'b1);
    for (int j = 0; j < MAX_JOINTS; j++)
      send_joint(32'sd421657428 * (j % 4), 32'sd1000 * j, 32'sh0001_0000,
                 32'sh0003_0000, 32'sd421657428, j == MAX_JOINTS - 1);
  endtask

  // More joints than the core holds: the extras are dropped and flagged.
  task automatic test_capacity();
    send_random_chain(MAX_JOINTS + 2);
    send_random_chain(MAX_JOINTS + 1);
  endtask

  // Random chains, with a stretch in the middle where neither side idles.
  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 85) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(MAX_JOINTS + 3, MAX_JOINTS + 1)
                                   : $urandom_range(MAX_JOINTS, 1);
      idle_enable = !(sent >= 30 && sent < 60);
      send_random_chain(n);
      sent += n;
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    joint_if.valid = 1'b0;
    joint_if.joint_angle = '0;
    joint_if.angle_offset = '0;
    joint_if.link_offset_d = '0;
    joint_if.link_length_a = '0;
    joint_if.link_twist = '0;
    joint_if.final_joint = 1'b0;
    column_if.ready = 1'b0;
    mismatches = 0;
    idle_enable = 1'b1;
    clear_chain();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity();
    test_random();
    joint_if.valid <= 1'b0;
    while (expected_columns.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (!timed_out) begin
      if (mismatches == 0 && expected_columns.size() == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) column_if.ready <= !(idle_enable && $urandom_range(99) < 33);
  end

  // Compares each accepted column with the oldest prediction.
  always @(posedge clk_i) begin
    column_t want;
    if (rst_ni && column_if.valid && column_if.ready) begin
      if (expected_columns.size() == 0) begin
        report_mismatch("unexpected word, index", column_if.column_index, -1);
      end else begin
        want = expected_columns.pop_front();
        if (column_if.lin_x != want.lin[0]) report_mismatch("lin_x", column_if.lin_x, want.lin[0]);
        if (column_if.lin_y != want.lin[1]) report_mismatch("lin_y", column_if.lin_y, want.lin[1]);
        if (column_if.lin_z != want.lin[2]) report_mismatch("lin_z", column_if.lin_z, want.lin[2]);
        if (column_if.ang_x != want.ang[0]) report_mismatch("ang_x", column_if.ang_x, want.ang[0]);
        if (column_if.ang_y != want.ang[1]) report_mismatch("ang_y", column_if.ang_y, want.ang[1]);
        if (column_if.ang_z != want.ang[2]) report_mismatch("ang_z", column_if.ang_z, want.ang[2]);
        if (column_if.tip_x != want.tip[0]) report_mismatch("tip_x", column_if.tip_x, want.tip[0]);
        if (column_if.tip_y != want.tip[1]) report_mismatch("tip_y", column_if.tip_y, want.tip[1]);
        if (column_if.tip_z != want.tip[2]) report_mismatch("tip_z", column_if.tip_z, want.tip[2]);
        if (column_if.column_index != want.idx)
          report_mismatch("column_index", column_if.column_index, want.idx);
        if (column_if.column_last != want.last)
          report_mismatch("column_last", column_if.column_last, want.last);
        if (column_if.joints_dropped != want.dropped)
          report_mismatch("joints_dropped", column_if.joints_dropped, want.dropped);
      end
    end
  end

  // A full chain of slow joints with long stalls passes well inside this limit.
  always @(posedge clk_i) begin
    if ((joint_if.valid && joint_if.ready) || (column_if.valid && column_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    quiet_cycles = 0;
    timed_out = 1'b0;
  end

endmodule

[dh_geometric_jacobian_core.f]
rtl/dhj_pkg.sv
rtl/dhj_intf.sv
rtl/dhj_front.sv
rtl/dhj_sincos.sv
rtl/dhj_back.sv
rtl/dh_geometric_jacobian_core.sv
verif/tb_dh_geometric_jacobian_core.sv
